// ----- rtl/core/mbe_pkg.sv -----
// Shared constants for the escape-time pixel engine: configuration register
// indexes and reset values, field widths, queue depth and palette constants.
// No dependencies.
package mbe_pkg;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;
    localparam int ORIGIN_W   = 32;
    localparam int STEP_W     = 31;
    localparam int ITER_W     = 16;
    localparam int COLOR_W    = 8;

    localparam logic [CFG_ADDR_W-1:0] REG_X_ORIGIN  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_Y_ORIGIN  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_X_STEP    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_Y_STEP    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_ITERS = 3'd4;

    // -2.0 in Q4.28
    localparam logic [ORIGIN_W-1:0] X_ORIGIN_RST  = 32'hE000_0000;
    localparam logic [ORIGIN_W-1:0] Y_ORIGIN_RST  = 32'hE000_0000;
    localparam logic [STEP_W-1:0]   X_STEP_RST    = 31'd0;
    localparam logic [STEP_W-1:0]   Y_STEP_RST    = 31'd0;
    localparam logic [ITER_W-1:0]   MAX_ITERS_RST = 16'd1000;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;

    localparam logic [COLOR_W-1:0] BAND_RED   = 8'd240;
    localparam int                 SHADE_BITS = 4;
    localparam int                 BAND_BIT   = 4;

endpackage

// ----- rtl/core/mbe_front.sv -----
// Front end: accepts pixel indexes and maps them to the point c in the
// complex plane, saturated to the fixed-point range. Depends on mbe_pkg.
module mbe_front #(
    parameter int FRAC_BITS  = 28,
    parameter int INDEX_BITS = 12
) (
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [INDEX_BITS-1:0]                 s_pixel_column,
    input  logic [INDEX_BITS-1:0]                 s_pixel_row,
    input  logic [mbe_pkg::ORIGIN_W-1:0]          x_origin,
    input  logic [mbe_pkg::ORIGIN_W-1:0]          y_origin,
    input  logic [mbe_pkg::STEP_W-1:0]            x_step,
    input  logic [mbe_pkg::STEP_W-1:0]            y_step,
    output logic                                  q_valid,
    input  logic                                  q_ready,
    output logic [2*(FRAC_BITS+4)-1:0]            q_data
);

    localparam int W      = FRAC_BITS + 4;
    localparam int PROD_W = INDEX_BITS + mbe_pkg::STEP_W;
    localparam int SUM_W  = (PROD_W + 2 > W + 1) ? PROD_W + 2 : W + 1;

    localparam logic [SUM_W-1:0] VAL_MAX_S = {{(SUM_W-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic [SUM_W-1:0] VAL_MIN_S = {{(SUM_W-W+1){1'b1}}, {(W-1){1'b0}}};

    function automatic logic [W-1:0] to_coord(
        input logic [mbe_pkg::ORIGIN_W-1:0] origin,
        input logic [mbe_pkg::STEP_W-1:0]   step,
        input logic [INDEX_BITS-1:0]        idx
    );
        logic [PROD_W-1:0] prod;
        logic [SUM_W-1:0]  sum;
        prod = PROD_W'(idx) * PROD_W'(step);
        sum  = SUM_W'($signed(origin)) + SUM_W'(prod);
        if ($signed(sum) > $signed(VAL_MAX_S)) begin
            return VAL_MAX_S[W-1:0];
        end else if ($signed(sum) < $signed(VAL_MIN_S)) begin
            return VAL_MIN_S[W-1:0];
        end
        return sum[W-1:0];
    endfunction

    assign s_ready = q_ready;
    assign q_valid = s_valid;
    // imaginary part in the upper half, real part in the lower half
    assign q_data  = {to_coord(y_origin, y_step, s_pixel_row),
                      to_coord(x_origin, x_step, s_pixel_column)};

endmodule

// ----- rtl/core/mbe_queue.sv -----
// Two-entry queue between the coordinate front end and the iteration unit.
// Depends on mbe_pkg for its depth.
module mbe_queue #(
    parameter int WIDTH = 64
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0]             entry_reg [mbe_pkg::Q_DEPTH];
    logic [mbe_pkg::Q_PTR_W-1:0]  wr_ptr_reg;
    logic [mbe_pkg::Q_PTR_W-1:0]  rd_ptr_reg;
    logic [mbe_pkg::Q_PTR_W:0]    fill_reg;
    logic [mbe_pkg::Q_PTR_W:0]    fill_next;
    logic                         push;
    logic                         pop;

    assign wr_ready = fill_reg != (mbe_pkg::Q_PTR_W+1)'(mbe_pkg::Q_DEPTH);
    assign rd_valid = fill_reg != '0;
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb begin
        fill_next = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            fill_reg <= fill_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- rtl/core/mbe_iter.sv -----
// Iteration unit: runs z = z*z + c for one point at a time, each step in a
// multiply state followed by a truncate/add/test state, and holds the result in an
// output register with its color. Depends on mbe_pkg.
module mbe_iter #(
    parameter int FRAC_BITS  = 28,
    parameter int COUNT_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              q_valid,
    output logic                              q_ready,
    input  logic [2*(FRAC_BITS+4)-1:0]        q_data,
    input  logic [mbe_pkg::ITER_W-1:0]        max_iters,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [COUNT_BITS-1:0]             m_iteration_count,
    output logic [mbe_pkg::COLOR_W-1:0]       m_red,
    output logic [mbe_pkg::COLOR_W-1:0]       m_green,
    output logic [mbe_pkg::COLOR_W-1:0]       m_blue
);

    localparam int W = FRAC_BITS + 4;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_MUL   = 2'd1;
    localparam logic [1:0] ST_CHECK = 2'd2;

    localparam logic [W-1:0]   VAL_MAX  = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]   VAL_MIN  = {1'b1, {(W-1){1'b0}}};
    localparam logic [2*W-1:0] VAL_MAX2 = {{(W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic [W:0]     ESCAPE   = {2'b00, 1'b1, {(FRAC_BITS+2){1'b0}}};

    // Truncate an exact product toward zero and saturate to the value range.
    function automatic logic [W-1:0] fx_trunc(input logic [2*W-1:0] p);
        logic           neg;
        logic [2*W-1:0] mag;
        logic [2*W-1:0] q;
        logic [W-1:0]   m;
        neg = p[2*W-1];
        mag = neg ? (~p + 1'b1) : p;
        q   = mag >> FRAC_BITS;
        m   = (q > VAL_MAX2) ? VAL_MAX : q[W-1:0];
        return neg ? (~m + 1'b1) : m;
    endfunction

    function automatic logic [W-1:0] sat1(input logic [W:0] v);
        if (v[W] != v[W-1]) begin
            return v[W] ? VAL_MIN : VAL_MAX;
        end
        return v[W-1:0];
    endfunction

    logic [1:0]                  state_reg;
    logic [1:0]                  state_next;
    logic [COUNT_BITS-1:0]       count_reg;
    logic [COUNT_BITS-1:0]       count_next;
    logic [W-1:0]                cr_reg;
    logic [W-1:0]                ci_reg;
    logic [W-1:0]                zr_reg;
    logic [W-1:0]                zi_reg;
    logic signed [2*W-1:0]       p_rr_reg;
    logic signed [2*W-1:0]       p_ii_reg;
    logic signed [2*W-1:0]       p_ri_reg;
    logic                        m_valid_reg;
    logic                        m_valid_next;
    logic [COUNT_BITS-1:0]       count_out_reg;
    logic [mbe_pkg::COLOR_W-1:0] red_reg;
    logic [mbe_pkg::COLOR_W-1:0] green_reg;
    logic [mbe_pkg::COLOR_W-1:0] blue_reg;

    logic [COUNT_BITS-1:0]       limit;
    logic [W-1:0]                rr;
    logic [W-1:0]                ii;
    logic [W-1:0]                ri;
    logic [W:0]                  mag_sum;
    logic [W-1:0]                diff_sat;
    logic [W-1:0]                twice_sat;
    logic [W-1:0]                zr_new;
    logic [W-1:0]                zi_new;
    logic                        at_limit;
    logic                        escaped;
    logic                        finish;
    logic                        out_free;
    logic                        load_out;
    logic [mbe_pkg::COLOR_W-1:0] shade;
    logic [mbe_pkg::COLOR_W-1:0] red_new;
    logic [mbe_pkg::COLOR_W-1:0] green_new;
    logic [mbe_pkg::COLOR_W-1:0] blue_new;

    assign limit     = COUNT_BITS'(max_iters);
    assign rr        = fx_trunc(p_rr_reg);
    assign ii        = fx_trunc(p_ii_reg);
    assign ri        = fx_trunc(p_ri_reg);
    assign mag_sum   = {1'b0, rr} + {1'b0, ii};
    assign diff_sat  = sat1({rr[W-1], rr} - {ii[W-1], ii});
    assign twice_sat = sat1({ri, 1'b0});
    assign zr_new    = sat1({diff_sat[W-1], diff_sat} + {cr_reg[W-1], cr_reg});
    assign zi_new    = sat1({twice_sat[W-1], twice_sat} + {ci_reg[W-1], ci_reg});

    // the products come from the latest z, so their sum is |z|^2 of that z
    assign escaped  = mag_sum >= ESCAPE;
    assign at_limit = count_reg == limit;
    assign finish   = escaped || at_limit;
    assign out_free = !m_valid_reg || m_ready;
    assign load_out = (state_reg == ST_CHECK) && finish && out_free;
    assign q_ready  = state_reg == ST_IDLE;

    assign shade = {count_reg[mbe_pkg::SHADE_BITS-1:0], {mbe_pkg::SHADE_BITS{1'b0}}};

    always_comb begin
        red_new   = '0;
        green_new = '0;
        blue_new  = '0;
        if (!at_limit) begin
            if (count_reg[mbe_pkg::BAND_BIT]) begin
                red_new   = mbe_pkg::BAND_RED;
                green_new = shade;
                blue_new  = shade;
            end else begin
                red_new   = shade;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    state_next = ST_MUL;
                    count_next = '0;
                end
            end
            ST_MUL: begin
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (!finish) begin
                    state_next = ST_MUL;
                    count_next = count_reg + 1'b1;
                end else if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && q_valid) begin
            cr_reg <= q_data[W-1:0];
            ci_reg <= q_data[2*W-1:W];
            zr_reg <= '0;
            zi_reg <= '0;
        end else if (state_reg == ST_CHECK && !finish) begin
            zr_reg <= zr_new;
            zi_reg <= zi_new;
        end
        if (state_reg == ST_MUL) begin
            p_rr_reg <= $signed(zr_reg) * $signed(zr_reg);
            p_ii_reg <= $signed(zi_reg) * $signed(zi_reg);
            p_ri_reg <= $signed(zr_reg) * $signed(zi_reg);
        end
        if (load_out) begin
            count_out_reg <= count_reg;
            red_reg       <= red_new;
            green_reg     <= green_new;
            blue_reg      <= blue_new;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_iteration_count = count_out_reg;
    assign m_red             = red_reg;
    assign m_green           = green_reg;
    assign m_blue            = blue_reg;

endmodule

// ----- rtl/core/mandelbrot_escape_time_pixel_top.sv -----
// Top level of the escape-time pixel engine: configuration registers, the
// coordinate front end, the two-entry queue and the iteration unit.
// Depends on mbe_pkg, mbe_front, mbe_queue and mbe_iter.
//
// Each accepted pixel (column, row) is mapped to c = origin + index * step in
// signed fixed point with FRAC_BITS fraction bits and four integer bits, then
// z = z*z + c is iterated from zero until the count reaches max_iters or
// |z|^2 >= 4; all arithmetic saturates. One result per pixel carries the
// count and an RGB color (black at the limit, otherwise a two-band palette).
// A pixel that runs n steps is taken from the queue in the idle state, then
// passes through a multiply state and a truncate/add/escape-test state for
// each step, plus one more such pair for the final escape or limit test.
// The front end and a two-entry queue take up to two further pixels while
// one iterates, and a finished result waits in the output register without
// holding up the next pixel until the following one finishes. Configuration
// is written through cfg_we/cfg_addr/cfg_wdata, one register per cycle.
module mandelbrot_escape_time_pixel_top #(
    parameter int FRAC_BITS  = 28,
    parameter int COUNT_BITS = 16,
    parameter int INDEX_BITS = 12
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [mbe_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [mbe_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [INDEX_BITS-1:0]             s_pixel_column,
    input  logic [INDEX_BITS-1:0]             s_pixel_row,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [COUNT_BITS-1:0]             m_iteration_count,
    output logic [mbe_pkg::COLOR_W-1:0]       m_red,
    output logic [mbe_pkg::COLOR_W-1:0]       m_green,
    output logic [mbe_pkg::COLOR_W-1:0]       m_blue
);

    localparam int QW = 2 * (FRAC_BITS + 4);

    logic [mbe_pkg::ORIGIN_W-1:0] x_origin_reg;
    logic [mbe_pkg::ORIGIN_W-1:0] y_origin_reg;
    logic [mbe_pkg::STEP_W-1:0]   x_step_reg;
    logic [mbe_pkg::STEP_W-1:0]   y_step_reg;
    logic [mbe_pkg::ITER_W-1:0]   max_iters_reg;

    logic          fq_valid;
    logic          fq_ready;
    logic [QW-1:0] fq_data;
    logic          qi_valid;
    logic          qi_ready;
    logic [QW-1:0] qi_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_origin_reg  <= mbe_pkg::X_ORIGIN_RST;
            y_origin_reg  <= mbe_pkg::Y_ORIGIN_RST;
            x_step_reg    <= mbe_pkg::X_STEP_RST;
            y_step_reg    <= mbe_pkg::Y_STEP_RST;
            max_iters_reg <= mbe_pkg::MAX_ITERS_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                mbe_pkg::REG_X_ORIGIN:  x_origin_reg  <= cfg_wdata;
                mbe_pkg::REG_Y_ORIGIN:  y_origin_reg  <= cfg_wdata;
                mbe_pkg::REG_X_STEP:    x_step_reg    <= cfg_wdata[mbe_pkg::STEP_W-1:0];
                mbe_pkg::REG_Y_STEP:    y_step_reg    <= cfg_wdata[mbe_pkg::STEP_W-1:0];
                mbe_pkg::REG_MAX_ITERS: max_iters_reg <= cfg_wdata[mbe_pkg::ITER_W-1:0];
                default: begin
                end
            endcase
        end
    end

    mbe_front #(
        .FRAC_BITS  (FRAC_BITS),
        .INDEX_BITS (INDEX_BITS)
    ) u_front (
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_pixel_column (s_pixel_column),
        .s_pixel_row    (s_pixel_row),
        .x_origin       (x_origin_reg),
        .y_origin       (y_origin_reg),
        .x_step         (x_step_reg),
        .y_step         (y_step_reg),
        .q_valid        (fq_valid),
        .q_ready        (fq_ready),
        .q_data         (fq_data)
    );

    mbe_queue #(
        .WIDTH (QW)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_data  (fq_data),
        .rd_valid (qi_valid),
        .rd_ready (qi_ready),
        .rd_data  (qi_data)
    );

    mbe_iter #(
        .FRAC_BITS  (FRAC_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_iter (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .q_valid           (qi_valid),
        .q_ready           (qi_ready),
        .q_data            (qi_data),
        .max_iters         (max_iters_reg),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_iteration_count (m_iteration_count),
        .m_red             (m_red),
        .m_green           (m_green),
        .m_blue            (m_blue)
    );

endmodule
